// ===== hdl/rtss_pkg.sv =====
// ----------------------------------------------------------------------------
// rtss_pkg: shared types, constants and helpers of the radix tree split search
// Code table geometry, input action codes, sequencer states and the
// leading-zero counter that forms the shared prefix compare unit.
// ----------------------------------------------------------------------------
package rtss_pkg;

    localparam int IDX_W   = 10;
    localparam int CODE_W  = 32;
    localparam int LZ_W    = 6;
    localparam int DEPTH   = 2 ** IDX_W;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 16;
    localparam int S_TUSER_W = 1;
    localparam int M_TUSER_W = 2;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CODE_W-1:0] code_t;
    typedef logic [LZ_W-1:0]   lz_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_FIRST,
        ST_RD_LAST,
        ST_CMP,
        ST_STEP,
        ST_TEST,
        ST_DONE
    } state_t;

    // Leading-zero count; an all-zero word counts as CODE_W.
    function automatic lz_t count_lz(input code_t v);
        lz_t n;
        n = lz_t'(CODE_W);
        for (int i = 0; i < CODE_W; i++)
        begin
            if (v[i])
            begin
                n = lz_t'(CODE_W - 1 - i);
            end
        end
        return n;
    endfunction

endpackage

// ===== hdl/radix_tree_split_search_top.sv =====
// ----------------------------------------------------------------------------
// radix_tree_split_search_top: split search over a table of sorted codes
// A load is written to the code table when accepted; a reversed range is
// answered with no table read, equal end codes after both ends are read, and
// a search after N halving steps, where N = ceil(log2(last - first)), at
// least 1 and up to 10.
// Throughput: one item at a time, set by the single read port of the code
// table and the shared XOR / leading-zero unit.
// Reset: rst_n clears the sequencer and output valid; the code table is not
// cleared and holds undefined data until written.
// ----------------------------------------------------------------------------
module radix_tree_split_search_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    // tdata: load_index[9:0], load_code[41:10], range_first[51:42],
    //        range_last[61:52], zero [63:62]
    input  logic [rtss_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: action[0]
    input  logic [rtss_pkg::S_TUSER_W-1:0] s_axis_tuser,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: split_index[9:0], zero [15:10]
    output logic [rtss_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // tuser: equal_ends[0], range_error[1]
    output logic [rtss_pkg::M_TUSER_W-1:0] m_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready
);
    import rtss_pkg::*;

    // Input field unpacking
    logic  in_action;
    idx_t  in_load_index;
    code_t in_load_code;
    idx_t  in_first;
    idx_t  in_last;

    assign in_action     = s_axis_tuser[0];
    assign in_load_index = s_axis_tdata[IDX_W-1:0];
    assign in_load_code  = s_axis_tdata[IDX_W+CODE_W-1:IDX_W];
    assign in_first      = s_axis_tdata[2*IDX_W+CODE_W-1:IDX_W+CODE_W];
    assign in_last       = s_axis_tdata[3*IDX_W+CODE_W-1:2*IDX_W+CODE_W];

    // Sequencer and datapath registers
    state_t             state_reg, state_next;
    idx_t               first_reg, first_next;
    idx_t               last_reg, last_next;
    code_t              fcode_reg, fcode_next;
    lz_t                common_reg, common_next;
    idx_t               pos_reg, pos_next;
    idx_t               step_reg, step_next;
    logic [IDX_W:0]     cand_reg, cand_next;
    idx_t               res_split_reg, res_split_next;
    logic               res_eq_reg, res_eq_next;
    logic               res_err_reg, res_err_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    idx_t               out_split_reg, out_split_next;
    logic               out_eq_reg, out_eq_next;
    logic               out_err_reg, out_err_next;

    // Code table: one write port, one registered read port
    code_t              code_mem [DEPTH];
    code_t              rd_data_reg;
    idx_t               rd_addr;
    logic               wr_en;

    // Shared prefix unit: XOR against the first code, then leading zeros
    code_t              xor_val;
    lz_t                lz_val;

    // Search step arithmetic
    logic [IDX_W:0]     step_inc;
    idx_t               step_half;
    logic [IDX_W:0]     cand_calc;
    logic [IDX_W:0]     mid_sum;
    logic               in_fire;
    logic               out_free;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    assign xor_val  = fcode_reg ^ rd_data_reg;
    assign lz_val   = count_lz(xor_val);

    assign step_inc  = {1'b0, step_reg} + (IDX_W+1)'(1);
    assign step_half = step_inc[IDX_W:1];
    assign cand_calc = {1'b0, pos_reg} + {1'b0, step_half};
    assign mid_sum   = {1'b0, first_reg} + {1'b0, last_reg};

    assign wr_en = in_fire && (in_action == ACT_LOAD);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            code_mem[in_load_index] <= in_load_code;
        end
        rd_data_reg <= code_mem[rd_addr];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (in_action == ACT_QUERY))
                begin
                    if (in_first > in_last)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_RD_FIRST;
                    end
                end
            end
            ST_RD_FIRST: state_next = ST_RD_LAST;
            ST_RD_LAST:  state_next = ST_CMP;
            ST_CMP:
            begin
                if (rd_data_reg == fcode_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP: state_next = ST_TEST;
            ST_TEST:
            begin
                if (step_reg > idx_t'(1))
                begin
                    state_next = ST_STEP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        first_next     = first_reg;
        last_next      = last_reg;
        fcode_next     = fcode_reg;
        common_next    = common_reg;
        pos_next       = pos_reg;
        step_next      = step_reg;
        cand_next      = cand_reg;
        res_split_next = res_split_reg;
        res_eq_next    = res_eq_reg;
        res_err_next   = res_err_reg;
        out_valid_next = out_valid_reg;
        out_split_next = out_split_reg;
        out_eq_next    = out_eq_reg;
        out_err_next   = out_err_reg;
        rd_addr        = first_reg;
        s_axis_tready  = 1'b0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (in_fire && (in_action == ACT_QUERY))
                begin
                    first_next     = in_first;
                    last_next      = in_last;
                    // reversed range: flag it, no table access
                    res_split_next = in_first;
                    res_eq_next    = 1'b0;
                    res_err_next   = 1'b1;
                end
            end
            ST_RD_FIRST:
            begin
                rd_addr = first_reg;
            end
            ST_RD_LAST:
            begin
                rd_addr    = last_reg;
                fcode_next = rd_data_reg;
            end
            ST_CMP:
            begin
                res_err_next = 1'b0;
                if (rd_data_reg == fcode_reg)
                begin
                    res_split_next = mid_sum[IDX_W:1];
                    res_eq_next    = 1'b1;
                end
                else
                begin
                    res_eq_next = 1'b0;
                    common_next = lz_val;
                    pos_next    = first_reg;
                    step_next   = last_reg - first_reg;
                end
            end
            ST_STEP:
            begin
                step_next = step_half;
                cand_next = cand_calc;
                rd_addr   = cand_calc[IDX_W-1:0];
            end
            ST_TEST:
            begin
                if ((cand_reg < {1'b0, last_reg}) && (lz_val > common_reg))
                begin
                    pos_next = cand_reg[IDX_W-1:0];
                end
                res_split_next = pos_next;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_split_next = res_split_reg;
                    out_eq_next    = res_eq_reg;
                    out_err_next   = res_err_reg;
                end
            end
            default:
            begin
                rd_addr = first_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg     <= first_next;
        last_reg      <= last_next;
        fcode_reg     <= fcode_next;
        common_reg    <= common_next;
        pos_reg       <= pos_next;
        step_reg      <= step_next;
        cand_reg      <= cand_next;
        res_split_reg <= res_split_next;
        res_eq_reg    <= res_eq_next;
        res_err_reg   <= res_err_next;
        out_split_reg <= out_split_next;
        out_eq_reg    <= out_eq_next;
        out_err_reg   <= out_err_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(M_TDATA_W-IDX_W)'(0), out_split_reg};
    assign m_axis_tuser  = {out_err_reg, out_eq_reg};

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the radix tree split search block
// Streams code loads and range queries into the block, predicts each split
// result from a shadow copy of the code table and checks results in order.
// Queries only touch table entries that were loaded first: before a query is
// sent, its search path is worked out and every entry on it not yet loaded
// is loaded from a sorted backing set of codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    import rtss_pkg::*;

    localparam int RANDOM_ITEMS = 850;
    localparam int HOLD_LEN     = 300;     // long receiver hold-off, in cycles
    localparam int SETTLE_CYC   = 40;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int DRAIN_EVERY  = 200;
    localparam int NO_IDLE_LEN  = 150;     // random items sent with no idling
    localparam realtime TIMEOUT = 5ms;

    // one expected (or observed) split result
    typedef struct packed {
        idx_t split;
        logic equal_ends;
        logic range_error;
    } split_res_t;

    // one input transaction
    typedef struct packed {
        logic  action;
        idx_t  load_index;
        code_t load_code;
        idx_t  range_first;
        idx_t  range_last;
    } item_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;

    // shadow of the block's code table and the backing set used for priming
    code_t code_shadow [DEPTH];
    bit    loaded      [DEPTH];
    code_t backing     [DEPTH];
    idx_t  search_path [$];

    split_res_t pending_splits [$];

    // idle control shared by sender and receiver
    logic no_idle     = 1'b0;
    int   hold_ticket = 0;
    int   hold_served = 0;
    int   hold_left   = 0;

    int n_sent    = 0;
    int n_loads   = 0;
    int n_queries = 0;
    int n_checked = 0;
    int n_errors  = 0;

    radix_tree_split_search_top u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Split predictor
    // ------------------------------------------------------------------------

    // shared prefix length of two codes: leading zeros of the XOR, 32 if equal
    function automatic int prefix_len(input code_t v);
        for (int b = CODE_W - 1; b >= 0; b--)
        begin
            if (v[b])
            begin
                return CODE_W - 1 - b;
            end
        end
        return CODE_W;
    endfunction

    // table read as the block sees it; unloaded entries fall back to the
    // backing set, which priming loads before the query goes out
    function automatic code_t fetch_code(input idx_t pos);
        search_path = {search_path, pos};
        return loaded[pos] ? code_shadow[pos] : backing[pos];
    endfunction

    function automatic split_res_t predict_split(input idx_t first, input idx_t last);
        split_res_t res;
        code_t      first_code;
        code_t      last_code;
        int         common;
        int         pos;
        int         stride;
        int         cand;
        res = '0;
        // reversed range: flagged, no table reads
        if (first > last)
        begin
            res.split       = first;
            res.range_error = 1'b1;
            return res;
        end
        first_code = fetch_code(first);
        last_code  = fetch_code(last);
        // equal end codes: midpoint
        if (first_code == last_code)
        begin
            res.split      = idx_t'((int'(first) + int'(last)) >> 1);
            res.equal_ends = 1'b1;
            return res;
        end
        // halving search for the highest index below last sharing a longer
        // prefix with the first code than the two end codes share
        common = prefix_len(first_code ^ last_code);
        pos    = int'(first);
        stride = int'(last) - int'(first);
        do
        begin
            stride = (stride + 1) >> 1;
            cand   = pos + stride;
            if (cand < int'(last))
            begin
                if (prefix_len(first_code ^ fetch_code(idx_t'(cand))) > common)
                begin
                    pos = cand;
                end
            end
        end
        while (stride > 1);
        res.split = idx_t'(pos);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Drives one transaction and returns on the edge it is accepted. tvalid
    // stays high on return so that a following item goes out back to back;
    // any path that lets time pass without sending lowers it first.
    task automatic send_item(input item_t it);
        int gap;
        gap = 0;
        if (!no_idle)
        begin
            while ($urandom_range(99) < 7)
            begin
                gap++;
            end
        end
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= {2'b00, it.range_last, it.range_first, it.load_code, it.load_index};
        s_axis_tuser  <= it.action;
        s_axis_tvalid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        n_sent++;
        // the block takes one item at a time, so the shadow is updated in
        // acceptance order
        if (it.action == ACT_LOAD)
        begin
            code_shadow[it.load_index] = it.load_code;
            loaded[it.load_index]      = 1'b1;
            n_loads++;
        end
        else
        begin
            search_path.delete();
            pending_splits = {pending_splits, predict_split(it.range_first, it.range_last)};
            n_queries++;
        end
    endtask

    task automatic send_load(input idx_t pos, input code_t code);
        item_t it;
        it.action      = ACT_LOAD;
        it.load_index  = pos;
        it.load_code   = code;
        it.range_first = idx_t'($urandom);   // ignored by a load
        it.range_last  = idx_t'($urandom);
        send_item(it);
    endtask

    // loads every entry the search will touch that is not loaded yet, then
    // sends the query
    task automatic query_range(input idx_t first, input idx_t last);
        idx_t       need [$];
        item_t      it;
        search_path.delete();
        void'(predict_split(first, last));
        need  = search_path;
        foreach (need[i])
        begin
            if (!loaded[need[i]])
            begin
                send_load(need[i], backing[need[i]]);
            end
        end
        it.action      = ACT_QUERY;
        it.load_index  = idx_t'($urandom);   // ignored by a query
        it.load_code   = $urandom;
        it.range_first = first;
        it.range_last  = last;
        send_item(it);
    endtask

    // sender pause until every expected result is in or DRAIN_LIMIT runs out, then let the block settle
    task automatic wait_drained();
        int cyc;
        cyc = 0;
        s_axis_tvalid <= 1'b0;
        while (pending_splits.size() != 0 && cyc < DRAIN_LIMIT)
        begin
            @(posedge clk);
            cyc++;
        end
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_served != hold_ticket)
        begin
            hold_served   <= hold_ticket;
            hold_left     <= HOLD_LEN;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= no_idle || ($urandom_range(99) >= 7);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: each accepted result against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        split_res_t got;
        split_res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.split       = m_axis_tdata[IDX_W-1:0];
            got.equal_ends  = m_axis_tuser[0];
            got.range_error = m_axis_tuser[1];
            n_checked++;
            if (pending_splits.size() == 0)
            begin
                n_errors++;
                $display("%0t: unexpected result, split_index %0d equal_ends %0b range_error %0b",
                         $time, got.split, got.equal_ends, got.range_error);
            end
            else
            begin
                want = pending_splits.pop_front();
                if (got.split !== want.split)
                begin
                    n_errors++;
                    $display("%0t: split_index mismatch, expected %0d, actual %0d",
                             $time, want.split, got.split);
                end
                if (got.equal_ends !== want.equal_ends)
                begin
                    n_errors++;
                    $display("%0t: equal_ends mismatch, expected %0b, actual %0b",
                             $time, want.equal_ends, got.equal_ends);
                end
                if (got.range_error !== want.range_error)
                begin
                    n_errors++;
                    $display("%0t: range_error mismatch, expected %0b, actual %0b",
                             $time, want.range_error, got.range_error);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // extreme indexes and codes, widest range, single-entry range at the top
    task automatic test_extremes();
        send_load(idx_t'(0), 32'h0000_0000);
        send_load(idx_t'(DEPTH - 1), 32'hFFFF_FFFF);
        query_range(idx_t'(0), idx_t'(DEPTH - 1));
        query_range(idx_t'(0), idx_t'(1));
        query_range(idx_t'(DEPTH - 1), idx_t'(DEPTH - 1));
    endtask

    // first above last: flagged, split is first
    task automatic test_reversed();
        query_range(idx_t'(DEPTH - 1), idx_t'(0));
        query_range(idx_t'(1), idx_t'(0));
        query_range(idx_t'(512), idx_t'(511));
    endtask

    // identical end codes give the midpoint
    task automatic test_equal_ends();
        send_load(idx_t'(100), 32'h1234_5678);
        send_load(idx_t'(103), 32'h1234_5678);
        query_range(idx_t'(100), idx_t'(103));
        query_range(idx_t'(100), idx_t'(100));
    endtask

    // a probe equal to the first code counts as a full 32-bit prefix
    task automatic test_identical_codes();
        send_load(idx_t'(200), 32'h8000_0001);
        send_load(idx_t'(201), 32'h8000_0001);
        send_load(idx_t'(202), 32'h8000_0001);
        send_load(idx_t'(203), 32'h8000_0003);
        query_range(idx_t'(200), idx_t'(203));
        wait_drained();
    endtask

    // random query; mostly short spans, a few wide ones, now and then the
    // whole table
    task automatic random_query();
        int first;
        int span;
        int pick;
        pick  = $urandom_range(99);
        first = $urandom_range(DEPTH - 1);
        if (pick < 85)
        begin
            span = $urandom_range(63);
        end
        else if (pick < 97)
        begin
            span = $urandom_range(DEPTH - 1);
        end
        else
        begin
            first = 0;
            span  = DEPTH - 1;
        end
        query_range(idx_t'(first), idx_t'((first + span > DEPTH - 1) ? DEPTH - 1 : first + span));
    endtask

    // receiver holds off while queries keep coming, so the block backs up
    task automatic test_backpressure();
        hold_ticket <= hold_ticket + 1;
        repeat (12) random_query();
        wait_drained();
    endtask

    // reload a run of sorted codes sharing a random prefix, then query inside
    // it; few free low bits make duplicate codes common
    task automatic reload_region();
        int    len;
        int    base;
        int    nfree;
        int    f;
        int    l;
        int    t;
        code_t prefix;
        code_t mask;
        code_t vals [$];
        len    = ($urandom_range(9) == 0) ? $urandom_range(2, 64) : $urandom_range(2, 16);
        base   = $urandom_range(DEPTH - len);
        nfree  = ($urandom_range(3) == 0) ? $urandom_range(4) : $urandom_range(5, CODE_W);
        mask   = (nfree == CODE_W) ? '1 : (code_t'(1) << nfree) - code_t'(1);
        prefix = $urandom;
        repeat (len) vals = {vals, code_t'((prefix & ~mask) | ($urandom & mask))};
        vals.sort();
        foreach (vals[i])
        begin
            send_load(idx_t'(base + i), vals[i]);
        end
        repeat ($urandom_range(2, 4))
        begin
            f = base + $urandom_range(len - 1);
            l = base + $urandom_range(len - 1);
            if (f > l && $urandom_range(3) != 0)
            begin
                t = f;
                f = l;
                l = t;
            end
            query_range(idx_t'(f), idx_t'(l));
        end
    endtask

    task automatic test_random();
        int start;
        int next_drain;
        int pick;
        start      = n_sent;
        next_drain = start + DRAIN_EVERY;
        no_idle   <= 1'b1;
        while (n_sent - start < RANDOM_ITEMS)
        begin
            if (no_idle && n_sent - start > NO_IDLE_LEN)
            begin
                no_idle <= 1'b0;
            end
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                reload_region();
            end
            else if (pick < 75)
            begin
                random_query();
            end
            else if (pick < 85)
            begin
                query_range(idx_t'($urandom_range(1, DEPTH - 1)), idx_t'(0) + idx_t'($urandom_range(0, 0)));
            end
            else
            begin
                // stray load with an unsorted code
                send_load(idx_t'($urandom), $urandom);
            end
            if (n_sent >= next_drain)
            begin
                wait_drained();
                next_drain = n_sent + DRAIN_EVERY;
            end
        end
        no_idle <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        code_t seed_codes [$];
        repeat (DEPTH) seed_codes = {seed_codes, code_t'($urandom)};
        seed_codes.sort();
        foreach (backing[i])
        begin
            backing[i] = seed_codes[i];
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_extremes();
        test_reversed();
        test_equal_ends();
        test_identical_codes();
        test_backpressure();
        test_random();

        wait_drained();
        if (pending_splits.size() != 0)
        begin
            n_errors++;
            $display("%0t: %0d expected results never arrived", $time, pending_splits.size());
        end
        $display("Run covered %0d transactions: %0d code loads and %0d range queries.",
                 n_sent, n_loads, n_queries);
        $display("%0d split results checked, %0d mismatches.", n_checked, n_errors);
        if (n_errors == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial
    begin
        #(TIMEOUT);
        $display("Test completed with failures");
        $finish;
    end

endmodule
